/* design/lmvs_pkg.sv */
// ----------------------------------------------------------------------------
// lmvs_pkg
// Shared constants, codes and types for the matrix LRU victim selector.
// ----------------------------------------------------------------------------
`default_nettype none

package lmvs_pkg;

    localparam int DEFAULT_NUM_FRAMES = 16;
    localparam int FRAMES_RESET       = 16;
    localparam int CFG_W              = 5;
    localparam int FRAME_W            = 4;
    localparam int PIN_W              = 16;

    localparam logic KIND_TOUCH  = 1'b0;
    localparam logic KIND_VICTIM = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_DONE = 3'b100
    } state_t;

    // Per-row control from the sequencer to the row datapath
    typedef struct packed {
        logic is_target;   // row being touched
        logic eligible;    // unpinned, victim request
        logic found;       // a candidate is already held
    } row_ctrl_t;

endpackage

`default_nettype wire

/* design/lru_matrix_victim_select_top.sv */
// ----------------------------------------------------------------------------
// lru_matrix_victim_select_top
// Matrix LRU victim selector: touch and victim requests over a row memory.
// ----------------------------------------------------------------------------
//  Channel   Ports                                         Direction
//  input     s_valid s_ready s_kind s_frame s_pinned_mask  in
//  result    m_valid m_ready m_victim_valid m_victim_frame m_none_free  out
//  config    cfg_wr_en cfg_wr_data                         in
//
//  An item visits each of the n active matrix rows in turn (n the active frame
//  count) through the single read port of the row RAM, then posts the result.
//  Touches outside the active count and any item with a count of zero skip the row visits.
//  Reset clears per-row valid bits at once; no clearing pass is needed.
//  A result waiting on m_ready holds the next item in the finish cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_matrix_victim_select_top #(
    parameter int NUM_FRAMES = lmvs_pkg::DEFAULT_NUM_FRAMES
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         cfg_wr_en,
    input  wire logic [lmvs_pkg::CFG_W-1:0]   cfg_wr_data,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic                         s_kind,
    input  wire logic [lmvs_pkg::FRAME_W-1:0] s_frame,
    input  wire logic [lmvs_pkg::PIN_W-1:0]   s_pinned_mask,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_victim_valid,
    output logic [lmvs_pkg::FRAME_W-1:0]      m_victim_frame,
    output logic                              m_none_free
);

    localparam int IDX_W = $clog2(NUM_FRAMES);
    localparam int CNT_W = $clog2(NUM_FRAMES + 1);
    localparam int CNT_RESET = (lmvs_pkg::FRAMES_RESET > NUM_FRAMES) ?
                               NUM_FRAMES : lmvs_pkg::FRAMES_RESET;

    lmvs_pkg::state_t state_reg, state_next;

    logic [CNT_W-1:0]               act_reg;
    logic [IDX_W-1:0]               idx_reg, idx_next;
    logic                           kind_reg;
    logic [lmvs_pkg::FRAME_W-1:0]   frame_reg;
    logic [lmvs_pkg::PIN_W-1:0]     pins_reg;
    logic                           found_reg, found_next;
    logic [lmvs_pkg::FRAME_W-1:0]   best_reg, best_next;
    logic [NUM_FRAMES-1:0]          best_key_reg, best_key_next;
    logic [NUM_FRAMES-1:0]          row_valid_reg;
    logic                           m_valid_reg;
    logic                           m_victim_valid_reg;
    logic [lmvs_pkg::FRAME_W-1:0]   m_victim_frame_reg;
    logic                           m_none_free_reg;

    logic                  accept, out_free, skip, last_row, row_pinned;
    logic                  rd_en, wr_en;
    logic [IDX_W-1:0]      rd_addr;
    logic [NUM_FRAMES-1:0] rd_data, row_data, col_mask, frame_bit, wr_row, key;
    logic                  take;
    lmvs_pkg::row_ctrl_t   ctrl;

    assign out_free = !m_valid_reg || m_ready;
    assign s_ready  = (state_reg == lmvs_pkg::ST_IDLE) ||
                      ((state_reg == lmvs_pkg::ST_DONE) && out_free);
    assign accept   = s_valid && s_ready;

    // Nothing to visit: empty count, or touch of an inactive frame
    assign skip = (act_reg == '0) ||
                  ((s_kind == lmvs_pkg::KIND_TOUCH) && (32'(s_frame) >= 32'(act_reg)));

    assign last_row = ((CNT_W'(idx_reg) + CNT_W'(1)) == act_reg);

    always_comb begin
        for (int j = 0; j < NUM_FRAMES; j++) begin
            col_mask[j]  = (32'(j) < 32'(act_reg));
            frame_bit[j] = (32'(j) == 32'(frame_reg));
        end
    end

    // Frames past the pin field have no pin bit
    assign row_pinned = (32'(idx_reg) < lmvs_pkg::PIN_W) ?
                        pins_reg[4'(idx_reg)] : 1'b0;

    // A row never written since reset reads as zero
    assign row_data = row_valid_reg[idx_reg] ? rd_data : '0;

    assign ctrl.is_target = (32'(idx_reg) == 32'(frame_reg));
    assign ctrl.eligible  = (kind_reg == lmvs_pkg::KIND_VICTIM) && !row_pinned;
    assign ctrl.found     = found_reg;

    lmvs_row_ops #(
        .NUM_FRAMES(NUM_FRAMES)
    ) u_row_ops (
        .row_data (row_data),
        .col_mask (col_mask),
        .frame_bit(frame_bit),
        .best_key (best_key_reg),
        .ctrl     (ctrl),
        .wr_row   (wr_row),
        .key      (key),
        .take     (take)
    );

    assign wr_en = (state_reg == lmvs_pkg::ST_SCAN) && (kind_reg == lmvs_pkg::KIND_TOUCH);

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        if (accept && !skip) begin
            rd_en = 1'b1;
        end else if ((state_reg == lmvs_pkg::ST_SCAN) && !last_row) begin
            rd_en   = 1'b1;
            rd_addr = idx_reg + IDX_W'(1);
        end
    end

    lmvs_ram #(
        .WIDTH(NUM_FRAMES),
        .DEPTH(NUM_FRAMES)
    ) u_matrix (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(idx_reg),
        .wr_data(wr_row),
        .rd_en  (rd_en),
        .rd_addr(rd_addr),
        .rd_data(rd_data)
    );

    always_comb begin
        state_next    = state_reg;
        idx_next      = idx_reg;
        found_next    = found_reg;
        best_next     = best_reg;
        best_key_next = best_key_reg;
        case (state_reg)
            lmvs_pkg::ST_IDLE: begin
            end
            lmvs_pkg::ST_SCAN: begin
                if (take) begin
                    found_next    = 1'b1;
                    best_next     = 4'(idx_reg);
                    best_key_next = key;
                end
                if (last_row) begin
                    state_next = lmvs_pkg::ST_DONE;
                end else begin
                    idx_next = idx_reg + IDX_W'(1);
                end
            end
            lmvs_pkg::ST_DONE: begin
                if (out_free) begin
                    state_next = lmvs_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = lmvs_pkg::ST_IDLE;
            end
        endcase
        if (accept) begin
            state_next    = skip ? lmvs_pkg::ST_DONE : lmvs_pkg::ST_SCAN;
            idx_next      = '0;
            found_next    = 1'b0;
            best_next     = '0;
            best_key_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= lmvs_pkg::ST_IDLE;
            act_reg       <= CNT_W'(CNT_RESET);
            row_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
            idx_reg       <= '0;
            found_reg     <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            found_reg <= found_next;
            if (cfg_wr_en) begin
                act_reg <= (32'(cfg_wr_data) > 32'(NUM_FRAMES)) ?
                           CNT_W'(NUM_FRAMES) : CNT_W'(cfg_wr_data);
            end
            if (wr_en) begin
                row_valid_reg[idx_reg] <= 1'b1;
            end
            // Post the result when the slot frees; drop it once transferred
            if ((state_reg == lmvs_pkg::ST_DONE) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        best_reg     <= best_next;
        best_key_reg <= best_key_next;
        if (accept) begin
            kind_reg  <= s_kind;
            frame_reg <= s_frame;
            pins_reg  <= s_pinned_mask;
        end
        if ((state_reg == lmvs_pkg::ST_DONE) && out_free) begin
            m_victim_valid_reg <= (kind_reg == lmvs_pkg::KIND_VICTIM) && found_reg;
            m_victim_frame_reg <= found_reg ? best_reg : '0;
            m_none_free_reg    <= (kind_reg == lmvs_pkg::KIND_VICTIM) && !found_reg;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_victim_valid = m_victim_valid_reg;
    assign m_victim_frame = m_victim_frame_reg;
    assign m_none_free    = m_none_free_reg;

endmodule

`default_nettype wire

/* design/lmvs_ram.sv */
// ----------------------------------------------------------------------------
// lmvs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module lmvs_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* design/lmvs_row_ops.sv */
// ----------------------------------------------------------------------------
// lmvs_row_ops
// Row datapath: builds the write-back row for a touch and ranks a row
// against the best candidate for a victim request.
// ----------------------------------------------------------------------------
`default_nettype none

module lmvs_row_ops #(
    parameter int NUM_FRAMES = lmvs_pkg::DEFAULT_NUM_FRAMES
) (
    input  wire logic [NUM_FRAMES-1:0] row_data,
    input  wire logic [NUM_FRAMES-1:0] col_mask,
    input  wire logic [NUM_FRAMES-1:0] frame_bit,
    input  wire logic [NUM_FRAMES-1:0] best_key,
    input  wire lmvs_pkg::row_ctrl_t   ctrl,
    output logic      [NUM_FRAMES-1:0] wr_row,
    output logic      [NUM_FRAMES-1:0] key,
    output logic                       take
);

    logic [NUM_FRAMES-1:0] masked;

    // Target row becomes all active ones; every row loses the touched column
    assign wr_row = (ctrl.is_target ? col_mask : row_data) & ~frame_bit;

    assign masked = row_data & col_mask;

    // Column 0 is the most significant bit of the key
    always_comb begin
        for (int j = 0; j < NUM_FRAMES; j++) begin
            key[NUM_FRAMES-1-j] = masked[j];
        end
    end

    assign take = ctrl.eligible && (!ctrl.found || (key < best_key));

endmodule

`default_nettype wire
